// ----- design/srv_pkg.sv -----
// Package for the Schroeder reverb: fixed widths, register indexes, loop lengths.
// No dependencies.
`timescale 1ns / 1ps
package srv_pkg;
  localparam int NumLines = 7;
  localparam int IntFrac = 4;
  // gains are Q0.15 and wet mix is Q1.15, tied to the register widths
  localparam int CoefFracBits = 15;
  // register indexes
  localparam logic [2:0] RegEnable  = 3'd0;
  localparam logic [2:0] RegWet     = 3'd1;
  localparam logic [2:0] RegGainA   = 3'd2;
  localparam logic [2:0] RegGainB   = 3'd3;
  localparam logic [2:0] RegGainC   = 3'd4;
  localparam logic [2:0] RegGainD   = 3'd5;
  localparam logic [2:0] RegApGain  = 3'd6;
  localparam logic [2:0] RegScale   = 3'd7;
  // nominal loop lengths before stretch
  localparam int unsigned Nominal [NumLines] = '{3460, 2988, 3882, 4312, 480, 161, 46};
endpackage

// ----- design/srv_mul.sv -----
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// Uses no package items.
`timescale 1ns / 1ps
module srv_mul #(
  parameter int ABits = 24,
  parameter int BBits = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ABits-1:0] a_i,
  input  logic        [BBits-1:0] b_i,
  output logic                    done_o,
  output logic signed [ABits+BBits:0] p_o
);
  localparam int CntBits = $clog2(BBits + 1);
  logic signed [ABits+BBits:0] acc_q, acc_d;
  logic signed [ABits+BBits:0] a_q, a_d;
  logic [BBits-1:0] b_q, b_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  // shift and add one bit of b each cycle
  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d = (ABits+BBits+1)'(a_i);
      b_d = b_i;
      cnt_d = CntBits'(BBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign p_o = acc_q;
endmodule

// ----- design/schroeder_reverb_top.sv -----
// Top level of the Schroeder reverb: config port, sequencer, delay memories.
// Depends on srv_pkg and srv_mul.
`timescale 1ns / 1ps
// Schroeder reverb: four feedback comb lines averaged, then three allpass lines,
// mixed with the dry sample. Disabled, a request passes straight through the StOut
// state to the output register. Enabled, one request takes 12 products on the
// shared bit-serial multiplier: one per comb line, two per allpass line and two
// for the mix, with a read and write step for each line. The input stalls while
// the sequencer is busy or a result waits, so the next request is taken at the
// earliest in the cycle after the result leaves. Any register write returns all
// loop positions to zero; line contents stay. After reset a clearing pass zeroes
// the delay memories, one address of all seven lines per cycle, through all
// STRETCH*4312 addresses before the first request is taken.
module schroeder_reverb_top #(
  parameter int Stretch = 2,
  parameter int SampleBits = 16,
  parameter int StoreBits = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [SampleBits-1:0] sample_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [SampleBits-1:0] sample_out_o
);
  import srv_pkg::*;

  localparam int MaxLen = 4312 * Stretch;
  localparam int PosBits = $clog2(MaxLen + 1);
  localparam int WBits = CoefFracBits + 1;
  localparam int MulBits = StoreBits + WBits + 1;
  localparam int MixBits = StoreBits + WBits + 2;
  localparam logic signed [StoreBits-1:0] SatHi = {1'b0, {(StoreBits-1){1'b1}}};
  localparam logic signed [StoreBits-1:0] SatLo = {1'b1, {(StoreBits-1){1'b0}}};
  localparam logic [WBits-1:0] Unity = WBits'(1) << CoefFracBits;

  // state codes
  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRead  = 4'd2;
  localparam logic [3:0] StRdat  = 4'd3;
  localparam logic [3:0] StMulA  = 4'd4;
  localparam logic [3:0] StMulB  = 4'd5;
  localparam logic [3:0] StWrite = 4'd6;
  localparam logic [3:0] StMix1  = 4'd7;
  localparam logic [3:0] StMix2  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  // configuration registers
  logic enable_q;
  logic [15:0] wet_q;
  logic [14:0] gain_q [5];
  logic [8:0] scale_q;
  logic cfg_wr;
  logic [2:0] cfg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      wet_q <= 16'd32768;
      gain_q[0] <= 15'd26378;
      gain_q[1] <= 15'd27099;
      gain_q[2] <= 15'd25657;
      gain_q[3] <= 15'd25035;
      gain_q[4] <= 15'd22938;
      scale_q <= 9'd256;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegEnable: enable_q <= pwdata[0];
        RegWet:    wet_q <= pwdata[15:0];
        RegGainA:  gain_q[0] <= pwdata[14:0];
        RegGainB:  gain_q[1] <= pwdata[14:0];
        RegGainC:  gain_q[2] <= pwdata[14:0];
        RegGainD:  gain_q[3] <= pwdata[14:0];
        RegApGain: gain_q[4] <= pwdata[14:0];
        RegScale:  scale_q <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegEnable: prdata = {31'd0, enable_q};
      RegWet:    prdata = {16'd0, wet_q};
      RegGainA:  prdata = {17'd0, gain_q[0]};
      RegGainB:  prdata = {17'd0, gain_q[1]};
      RegGainC:  prdata = {17'd0, gain_q[2]};
      RegGainD:  prdata = {17'd0, gain_q[3]};
      RegApGain: prdata = {17'd0, gain_q[4]};
      RegScale:  prdata = {23'd0, scale_q};
      default:   prdata = '0;
    endcase
  end

  // loop lengths: (min(scale,256)*nominal*Stretch)>>8, at least 1; constant multiply per line
  logic [8:0] scale_eff;
  logic [PosBits-1:0] len [NumLines];
  assign scale_eff = (scale_q > 9'd256) ? 9'd256 : scale_q;
  for (genvar k = 0; k < NumLines; k++) begin : g_len
    localparam int Nom = Nominal[k] * Stretch;
    logic [PosBits+8:0] prod;
    assign prod = (PosBits+9)'(scale_eff) * (PosBits+9)'(Nom);
    assign len[k] = (prod[PosBits+8:8] == '0) ? PosBits'(1) : PosBits'(prod[PosBits+8:8]);
  end

  // read/write positions
  logic [PosBits-1:0] pos_q [NumLines];

  // delay memories, one per line
  localparam int D0 = 3460 * Stretch;
  localparam int D1 = 2988 * Stretch;
  localparam int D2 = 3882 * Stretch;
  localparam int D3 = 4312 * Stretch;
  localparam int D4 = 480 * Stretch;
  localparam int D5 = 161 * Stretch;
  localparam int D6 = 46 * Stretch;
  localparam int A0 = $clog2(D0);
  localparam int A1 = $clog2(D1);
  localparam int A2 = $clog2(D2);
  localparam int A3 = $clog2(D3);
  localparam int A4 = $clog2(D4);
  localparam int A5 = $clog2(D5);
  localparam int A6 = $clog2(D6);
  logic signed [StoreBits-1:0] mem0 [D0];
  logic signed [StoreBits-1:0] mem1 [D1];
  logic signed [StoreBits-1:0] mem2 [D2];
  logic signed [StoreBits-1:0] mem3 [D3];
  logic signed [StoreBits-1:0] mem4 [D4];
  logic signed [StoreBits-1:0] mem5 [D5];
  logic signed [StoreBits-1:0] mem6 [D6];
  logic signed [StoreBits-1:0] rd_q [NumLines];
  logic [PosBits-1:0] addr;
  logic we;
  logic [2:0] line_q;
  logic signed [StoreBits-1:0] wdata;

  logic [3:0] state_q, state_d;
  logic [PosBits-1:0] clr_q;
  logic signed [IntFrac+SampleBits-1:0] xf_q;
  logic signed [StoreBits+1:0] csum_q;
  logic signed [StoreBits-1:0] r_q, y_q;
  logic signed [StoreBits-1:0] ysel;
  logic signed [SampleBits-1:0] out_q;
  logic out_valid_q;
  logic signed [MixBits-1:0] mix_q;

  // shared multiplier
  logic mul_start;
  logic signed [StoreBits-1:0] mul_a;
  logic [WBits-1:0] mul_b;
  logic mul_done;
  logic signed [StoreBits+WBits:0] mul_p;
  srv_mul #(.ABits(StoreBits), .BBits(WBits)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  function automatic logic signed [StoreBits-1:0] sat(input logic signed [MulBits:0] v);
    if (v > (MulBits+1)'(SatHi)) return SatHi;
    if (v < (MulBits+1)'(SatLo)) return SatLo;
    return StoreBits'(v);
  endfunction

  logic signed [MulBits:0] shp;
  assign shp = (MulBits+1)'(mul_p >>> CoefFracBits);
  assign ysel = rd_q[line_q];

  // clearing pass writes all lines; otherwise one line at its position
  assign addr = (state_q == StClear) ? clr_q : pos_q[line_q];

  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      if (clr_q < PosBits'(D0)) mem0[clr_q[A0-1:0]] <= '0;
      if (clr_q < PosBits'(D1)) mem1[clr_q[A1-1:0]] <= '0;
      if (clr_q < PosBits'(D2)) mem2[clr_q[A2-1:0]] <= '0;
      if (clr_q < PosBits'(D3)) mem3[clr_q[A3-1:0]] <= '0;
      if (clr_q < PosBits'(D4)) mem4[clr_q[A4-1:0]] <= '0;
      if (clr_q < PosBits'(D5)) mem5[clr_q[A5-1:0]] <= '0;
      if (clr_q < PosBits'(D6)) mem6[clr_q[A6-1:0]] <= '0;
    end else if (we) begin
      unique case (line_q)
        3'd0: mem0[addr[A0-1:0]] <= wdata;
        3'd1: mem1[addr[A1-1:0]] <= wdata;
        3'd2: mem2[addr[A2-1:0]] <= wdata;
        3'd3: mem3[addr[A3-1:0]] <= wdata;
        3'd4: mem4[addr[A4-1:0]] <= wdata;
        3'd5: mem5[addr[A5-1:0]] <= wdata;
        3'd6: mem6[addr[A6-1:0]] <= wdata;
        default: ;
      endcase
    end
    if (state_q == StRead) begin
      unique case (line_q)
        3'd0: rd_q[0] <= mem0[addr[A0-1:0]];
        3'd1: rd_q[1] <= mem1[addr[A1-1:0]];
        3'd2: rd_q[2] <= mem2[addr[A2-1:0]];
        3'd3: rd_q[3] <= mem3[addr[A3-1:0]];
        3'd4: rd_q[4] <= mem4[addr[A4-1:0]];
        3'd5: rd_q[5] <= mem5[addr[A5-1:0]];
        3'd6: rd_q[6] <= mem6[addr[A6-1:0]];
        default: ;
      endcase
    end
  end

  logic accept_in, accept_out;
  assign accept_in = in_valid_i && !in_stall_o;
  assign accept_out = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;

  logic [WBits-1:0] wet_eff;
  assign wet_eff = (wet_q > 16'(Unity)) ? Unity : WBits'(wet_q);
  logic signed [StoreBits-1:0] xf_ext;
  assign xf_ext = StoreBits'(xf_q);
  logic is_comb;
  assign is_comb = line_q < 3'd4;

  // mix result truncated toward zero and saturated
  logic signed [MixBits-1:0] mix_sum;
  logic signed [MixBits-1:0] mix_div;
  assign mix_sum = mix_q + MixBits'(mul_p);
  assign mix_div = (mix_sum < 0)
      ? -((-mix_sum) >>> (CoefFracBits + IntFrac))
      : (mix_sum >>> (CoefFracBits + IntFrac));
  localparam logic signed [SampleBits-1:0] OutHi = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] OutLo = {1'b1, {(SampleBits-1){1'b0}}};

  always_comb begin
    state_d = state_q;
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    we = 1'b0;
    wdata = '0;
    unique case (state_q)
      StClear: if (clr_q == PosBits'(MaxLen - 1)) state_d = StIdle;
      StIdle: if (accept_in) state_d = enable_q ? StRead : StOut;
      StRead: state_d = StRdat;
      StRdat: begin
        // allpass first scales x; comb goes straight to feedback product
        mul_start = 1'b1;
        if (is_comb) begin
          mul_a = ysel; mul_b = WBits'(gain_q[line_q]);
          state_d = StMulB;
        end else begin
          mul_a = r_q; mul_b = WBits'(gain_q[4]);
          state_d = StMulA;
        end
      end
      StMulA: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = sat((MulBits+1)'(ysel) - shp);
        mul_b = WBits'(gain_q[4]);
        state_d = StMulB;
      end
      StMulB: if (mul_done) state_d = StWrite;
      StWrite: begin
        we = 1'b1;
        wdata = sat((MulBits+1)'(is_comb ? xf_ext : r_q) + shp);
        if (line_q == 3'd6) begin
          mul_start = 1'b1;
          mul_a = xf_ext; mul_b = Unity - wet_eff;
          state_d = StMix1;
        end else state_d = StRead;
      end
      StMix1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = r_q; mul_b = wet_eff;
        state_d = StMix2;
      end
      StMix2: if (mul_done) state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      line_q <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumLines; k++) pos_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (accept_out) out_valid_q <= 1'b0;
      if (state_q == StOut) out_valid_q <= 1'b1;
      if (state_q == StIdle) line_q <= '0;
      if (state_q == StWrite) begin
        line_q <= line_q + 1'b1;
        pos_q[line_q] <= (pos_q[line_q] + 1'b1 >= len[line_q]) ? '0 : pos_q[line_q] + 1'b1;
      end
      if (state_q == StRead && pos_q[line_q] >= len[line_q]) pos_q[line_q] <= '0;
      if (cfg_wr) for (int k = 0; k < NumLines; k++) pos_q[k] <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      xf_q <= (IntFrac+SampleBits)'(sample_in_i) <<< IntFrac;
      csum_q <= '0;
      out_q <= sample_in_i;
    end
    if (state_q == StWrite && is_comb) begin
      if (line_q == 3'd3)
        r_q <= sat((MulBits+1)'((csum_q + (StoreBits+2)'(ysel)) >>> 2));
      else
        csum_q <= csum_q + (StoreBits+2)'(ysel);
    end
    if (state_q == StMulA && mul_done) y_q <= sat((MulBits+1)'(ysel) - shp);
    if (state_q == StWrite && !is_comb) r_q <= y_q;
    if (state_q == StMix1 && mul_done) mix_q <= MixBits'(mul_p);
    if (state_q == StMix2 && mul_done) begin
      if (mix_div > MixBits'(OutHi)) out_q <= OutHi;
      else if (mix_div < MixBits'(OutLo)) out_q <= OutLo;
      else out_q <= SampleBits'(mix_div);
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_out_o = out_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_out_o)))
    else $error("stalled result changed");
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (line_q < 3'd7)) else $error("line index out of range");
endmodule
